>>> hdl/npcc_pkg.sv
`timescale 1ns / 1ps

package npcc_pkg;

    // palette storage
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int CNT_W     = PAL_AW + 1;
    localparam int SIZE_W    = 9;

    // colour widths
    localparam int IN_W   = 10;
    localparam int CHAN_W = 8;
    localparam int SQ_W   = 2 * CHAN_W;
    localparam int ERR_W  = SQ_W + 2;

    // memo cache, one word per 5:5:5 bucket
    localparam int KEY_BITS    = 5;
    localparam int CACHE_AW    = 3 * KEY_BITS;
    localparam int EPOCH_W     = 8;
    localparam int CACHE_W     = EPOCH_W + PAL_AW;

    // item command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef logic [CHAN_W-1:0]   chan_t;
    typedef logic [CACHE_AW-1:0] key_t;
    typedef logic [EPOCH_W-1:0]  epoch_t;

    // controller to datapath
    typedef struct packed {
        logic pal_write;
        logic cap_query;
        logic clear_start;
        logic clear_run;
        logic epoch_bump;
        logic cache_rd;
        logic cache_wr;
        logic scan_start;
        logic scan_run;
        logic res_empty;
        logic res_hit;
        logic res_best;
        logic out_load;
    } npcc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_query;
        logic size_zero;
        logic epoch_last;
        logic clear_last;
        logic cache_hit;
        logic scan_done;
    } npcc_stat_t;

    // saturate a signed channel to 0..255
    function automatic chan_t clamp_chan(input logic signed [IN_W-1:0] v);
        chan_t c;
        if (v[IN_W-1])
        begin
            c = '0;
        end
        else if (|v[IN_W-2:CHAN_W])
        begin
            c = '1;
        end
        else
        begin
            c = v[CHAN_W-1:0];
        end
        return c;
    endfunction

    // bucket index from the top five bits of each channel
    function automatic key_t cache_key(input chan_t r, input chan_t g, input chan_t b);
        return {r[CHAN_W-1 -: KEY_BITS], g[CHAN_W-1 -: KEY_BITS], b[CHAN_W-1 -: KEY_BITS]};
    endfunction

endpackage

>>> hdl/npcc_if.sv
`timescale 1ns / 1ps

// input item channel
interface npcc_item_if import npcc_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [PAL_AW-1:0]      entry_slot;
    logic signed [IN_W-1:0] red;
    logic signed [IN_W-1:0] green;
    logic signed [IN_W-1:0] blue;

    modport source (output valid, cmd, entry_slot, red, green, blue, input ready);
    modport sink   (input valid, cmd, entry_slot, red, green, blue, output ready);
endinterface

// result channel
interface npcc_result_if import npcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PAL_AW-1:0] best_entry;
    logic              palette_empty;

    modport source (output valid, best_entry, palette_empty, input ready);
    modport sink   (input valid, best_entry, palette_empty, output ready);
endinterface

// configuration write channel
interface npcc_cfg_if import npcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] palette_size;

    modport source (output valid, palette_size, input ready);
    modport sink   (input valid, palette_size, output ready);
endinterface

>>> hdl/npcc_datapath.sv
`timescale 1ns / 1ps

module npcc_datapath import npcc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  npcc_cmd_t              cmd,
    output npcc_stat_t             stat,
    input  logic                   item_cmd,
    input  logic [PAL_AW-1:0]      item_slot,
    input  logic signed [IN_W-1:0] item_red,
    input  logic signed [IN_W-1:0] item_green,
    input  logic signed [IN_W-1:0] item_blue,
    input  logic                   cfg_write,
    input  logic [SIZE_W-1:0]      cfg_size,
    output logic [PAL_AW-1:0]      best_entry,
    output logic                   palette_empty
);

    logic [3*CHAN_W-1:0] pal_mem [PAL_DEPTH];
    logic [CACHE_W-1:0]  cache_mem [1 << CACHE_AW];

    logic [SIZE_W-1:0]   size_reg;
    epoch_t              epoch_reg;
    key_t                clear_addr_reg;

    chan_t               cl_r, cl_g, cl_b;
    chan_t               q_r_reg, q_g_reg, q_b_reg;
    key_t                key_reg;
    logic [CACHE_W-1:0]  cache_q_reg;

    logic [CNT_W-1:0]    count;
    logic [CNT_W-1:0]    scan_idx_reg;
    logic                issue;
    logic [3*CHAN_W-1:0] pal_q_reg;
    logic                v1_reg, v2_reg;
    logic [PAL_AW-1:0]   i1_reg, i2_reg;
    logic [SQ_W-1:0]     sq_r_reg, sq_g_reg, sq_b_reg;
    logic [ERR_W-1:0]    err_sum;
    logic [ERR_W-1:0]    best_err_reg;
    logic [PAL_AW-1:0]   best_reg;

    logic signed [CHAN_W:0]     dr, dg, db;
    logic signed [2*CHAN_W+1:0] pr, pg, pb;

    logic [PAL_AW-1:0]   res_entry_reg;
    logic                res_empty_reg;
    logic [PAL_AW-1:0]   best_entry_reg;
    logic                palette_empty_reg;

    // clamp the incoming colour
    assign cl_r = clamp_chan(item_red);
    assign cl_g = clamp_chan(item_green);
    assign cl_b = clamp_chan(item_blue);

    // entries in use
    assign count = (size_reg > SIZE_W'(PAL_DEPTH)) ? CNT_W'(PAL_DEPTH) : CNT_W'(size_reg);
    assign issue = cmd.scan_run && (scan_idx_reg != count);

    // status back to the controller
    assign stat.in_query   = (item_cmd == CMD_QUERY);
    assign stat.size_zero  = (count == '0);
    assign stat.epoch_last = (epoch_reg == '1);
    assign stat.clear_last = (clear_addr_reg == '1);
    assign stat.cache_hit  = (cache_q_reg[CACHE_W-1 -: EPOCH_W] == epoch_reg);
    assign stat.scan_done  = (scan_idx_reg == count) && !v1_reg && !v2_reg;

    // size register, epoch and clearing counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= '0;
            epoch_reg      <= epoch_t'(1);
            clear_addr_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                size_reg <= cfg_size;
            end
            if (cmd.clear_start)
            begin
                epoch_reg      <= epoch_t'(1);
                clear_addr_reg <= '0;
            end
            else
            begin
                if (cmd.epoch_bump)
                begin
                    epoch_reg <= epoch_reg + epoch_t'(1);
                end
                if (cmd.clear_run)
                begin
                    clear_addr_reg <= clear_addr_reg + key_t'(1);
                end
            end
        end
    end

    // palette memory
    always_ff @(posedge clk)
    begin
        if (cmd.pal_write)
        begin
            pal_mem[item_slot] <= {cl_r, cl_g, cl_b};
        end
        if (issue)
        begin
            pal_q_reg <= pal_mem[scan_idx_reg[PAL_AW-1:0]];
        end
    end

    // cache memory, tag zero marks a cleared bucket
    always_ff @(posedge clk)
    begin
        if (cmd.clear_run)
        begin
            cache_mem[clear_addr_reg] <= '0;
        end
        else if (cmd.cache_wr)
        begin
            cache_mem[key_reg] <= {epoch_reg, best_reg};
        end
        if (cmd.cache_rd)
        begin
            cache_q_reg <= cache_mem[key_reg];
        end
    end

    // query capture
    always_ff @(posedge clk)
    begin
        if (cmd.cap_query)
        begin
            q_r_reg <= cl_r;
            q_g_reg <= cl_g;
            q_b_reg <= cl_b;
            key_reg <= cache_key(cl_r, cl_g, cl_b);
        end
    end

    // distance terms from the fetched entry
    assign dr = $signed({1'b0, q_r_reg}) - $signed({1'b0, pal_q_reg[3*CHAN_W-1 -: CHAN_W]});
    assign dg = $signed({1'b0, q_g_reg}) - $signed({1'b0, pal_q_reg[2*CHAN_W-1 -: CHAN_W]});
    assign db = $signed({1'b0, q_b_reg}) - $signed({1'b0, pal_q_reg[CHAN_W-1:0]});
    assign pr = dr * dr;
    assign pg = dg * dg;
    assign pb = db * db;
    assign err_sum = ERR_W'(sq_r_reg) + ERR_W'(sq_g_reg) + ERR_W'(sq_b_reg);

    // scan pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                scan_idx_reg <= scan_idx_reg + CNT_W'(1);
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
        end
    end

    // scan pipeline data: squares, then sum and compare
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            i1_reg <= scan_idx_reg[PAL_AW-1:0];
        end
        if (v1_reg)
        begin
            sq_r_reg <= pr[SQ_W-1:0];
            sq_g_reg <= pg[SQ_W-1:0];
            sq_b_reg <= pb[SQ_W-1:0];
            i2_reg   <= i1_reg;
        end
        if (cmd.scan_start)
        begin
            best_err_reg <= '1;
            best_reg     <= '0;
        end
        else if (v2_reg && (err_sum < best_err_reg))
        begin
            best_err_reg <= err_sum;
            best_reg     <= i2_reg;
        end
    end

    // result and output words
    always_ff @(posedge clk)
    begin
        if (cmd.res_empty)
        begin
            res_entry_reg <= '0;
            res_empty_reg <= 1'b1;
        end
        else if (cmd.res_hit)
        begin
            res_entry_reg <= cache_q_reg[PAL_AW-1:0];
            res_empty_reg <= 1'b0;
        end
        else if (cmd.res_best)
        begin
            res_entry_reg <= best_reg;
            res_empty_reg <= 1'b0;
        end
        if (cmd.out_load)
        begin
            best_entry_reg    <= res_entry_reg;
            palette_empty_reg <= res_empty_reg;
        end
    end

    assign best_entry    = best_entry_reg;
    assign palette_empty = palette_empty_reg;

endmodule

>>> hdl/npcc_ctrl.sv
`timescale 1ns / 1ps

module npcc_ctrl import npcc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic       cfg_valid,
    output logic       result_valid,
    input  logic       result_ready,
    input  npcc_stat_t stat,
    output npcc_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_SCAN,
        S_STORE,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   item_acc;
    logic   bump_req;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign item_acc     = item_valid && item_ready;

    // a load or a size write invalidates the cache
    assign bump_req = ((item_acc && !stat.in_query) || cfg_valid) && (state_reg != S_CLEAR);

    // commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.pal_write  = item_acc && !stat.in_query;
        cmd.cap_query  = item_acc && stat.in_query;
        if (bump_req)
        begin
            if (stat.epoch_last)
            begin
                cmd.clear_start = 1'b1;
            end
            else
            begin
                cmd.epoch_bump = 1'b1;
            end
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_run = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (bump_req && stat.epoch_last)
                begin
                    state_next = S_CLEAR;
                end
                else if (item_acc && stat.in_query)
                begin
                    if (stat.size_zero)
                    begin
                        cmd.res_empty = 1'b1;
                        state_next    = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP:
            begin
                cmd.cache_rd = 1'b1;
                state_next   = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.cache_hit)
                begin
                    cmd.res_hit = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.cache_wr = 1'b1;
                cmd.res_best = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.out_load = !out_valid_reg || result_ready;
                if (cmd.out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/nearest_palette_color_cached_unit.sv
`timescale 1ns / 1ps

// channel  | dir | handshake    | word
// ---------+-----+--------------+---------------------------------------------
// item     | in  | valid/ready  | cmd, entry_slot, red, green, blue
// result   | out | valid/ready  | best_entry, palette_empty
// cfg      | in  | valid/ready  | palette_size (ready always high)
//
// a load is written to the palette as it is taken; a hit query passes lookup
// and check on its way to the output register; a miss also a scan and store,
// paced by the one palette read port and the shared squared-distance unit.
// after reset, and after every 255th cache invalidation (load or size write)
// taken while idle, a clearing pass walks the 32768 cache buckets,
// one per cycle, with no item taken; size writes are taken during it.
// one item is in work at a time; the next is taken while a word still waits
// in the output register, and a stalled output then holds that item's result
// in the sequencer, so no further item is taken until the register frees.

module nearest_palette_color_cached_unit import npcc_pkg::*; (
    input logic          clk,
    input logic          rst_n,
    npcc_item_if.sink    item,
    npcc_result_if.source result,
    npcc_cfg_if.sink     cfg
);

    npcc_cmd_t  cmd;
    npcc_stat_t stat;

    // size writes are never held off
    assign cfg.ready = 1'b1;

    // sequencer
    npcc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .cfg_valid    (cfg.valid),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // storage and distance pipeline
    npcc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .item_cmd      (item.cmd),
        .item_slot     (item.entry_slot),
        .item_red      (item.red),
        .item_green    (item.green),
        .item_blue     (item.blue),
        .cfg_write     (cfg.valid),
        .cfg_size      (cfg.palette_size),
        .best_entry    (result.best_entry),
        .palette_empty (result.palette_empty)
    );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top import npcc_pkg::*; ();

    localparam int CACHE_SLOTS     = 1 << CACHE_AW;
    localparam int ITEMS_PER_MODE  = 580;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT  = 120000;
    localparam int RECENT_DEPTH    = 8;

    typedef struct {
        logic                   cmd;
        logic [PAL_AW-1:0]      entry_slot;
        logic signed [IN_W-1:0] red;
        logic signed [IN_W-1:0] green;
        logic signed [IN_W-1:0] blue;
    } color_item_t;

    typedef struct {
        logic [PAL_AW-1:0] best;
        logic              empty;
    } nearest_t;

    // palette copy, memo cache and the answers still owed by the block
    class nearest_color_board;
        logic [CHAN_W-1:0] pal_r [PAL_DEPTH];
        logic [CHAN_W-1:0] pal_g [PAL_DEPTH];
        logic [CHAN_W-1:0] pal_b [PAL_DEPTH];
        int unsigned       size_reg;
        int unsigned       epoch;
        int unsigned       bucket_tag [CACHE_SLOTS];
        logic [PAL_AW-1:0] bucket_best [CACHE_SLOTS];
        nearest_t          owed_answers [$];
        int                n_loads;
        int                n_queries;
        int                n_empty;
        int                n_cached;
        int                n_sizes;
        int                n_checked;
        int                n_errors;

        function new();
            epoch    = 1;
            size_reg = 0;
        endfunction

        // saturate a signed channel to 0..255
        function logic [CHAN_W-1:0] sat8(logic signed [IN_W-1:0] v);
            if (v < 0)
            begin
                return '0;
            end
            if (v > 255)
            begin
                return '1;
            end
            return v[CHAN_W-1:0];
        endfunction

        // a new size changes the entries in use, so every bucket goes stale
        function void set_size(int unsigned v);
            size_reg = v;
            epoch++;
            n_sizes++;
        endfunction

        function int pending();
            return owed_answers.size();
        endfunction

        function void take_item(color_item_t w);
            logic [CHAN_W-1:0]   r;
            logic [CHAN_W-1:0]   g;
            logic [CHAN_W-1:0]   b;
            logic [CACHE_AW-1:0] key;
            int unsigned         count;
            int unsigned         best;
            int unsigned         best_err;
            int unsigned         err;
            int                  dr;
            int                  dg;
            int                  db;
            nearest_t            ans;
            r = sat8(w.red);
            g = sat8(w.green);
            b = sat8(w.blue);
            // load: store the saturated colour and drop every cached answer
            if (w.cmd == CMD_LOAD)
            begin
                pal_r[w.entry_slot] = r;
                pal_g[w.entry_slot] = g;
                pal_b[w.entry_slot] = b;
                epoch++;
                n_loads++;
                return;
            end
            n_queries++;
            count = (size_reg > PAL_DEPTH) ? PAL_DEPTH : size_reg;
            // empty palette answers without touching the cache
            if (count == 0)
            begin
                ans.best  = '0;
                ans.empty = 1'b1;
                n_empty++;
                owed_answers.insert(owed_answers.size(), ans);
                return;
            end
            key = {r[CHAN_W-1 -: KEY_BITS], g[CHAN_W-1 -: KEY_BITS], b[CHAN_W-1 -: KEY_BITS]};
            if (bucket_tag[key] == epoch)
            begin
                ans.best = bucket_best[key];
                n_cached++;
            end
            else
            begin
                // full scan, strict less-than keeps the lowest index on ties
                best     = 0;
                best_err = 32'hFFFF_FFFF;
                for (int i = 0; i < count; i++)
                begin
                    dr  = int'(r) - int'(pal_r[i]);
                    dg  = int'(g) - int'(pal_g[i]);
                    db  = int'(b) - int'(pal_b[i]);
                    err = dr * dr + dg * dg + db * db;
                    if (err < best_err)
                    begin
                        best_err = err;
                        best     = i;
                    end
                end
                bucket_tag[key]  = epoch;
                bucket_best[key] = PAL_AW'(best);
                ans.best         = PAL_AW'(best);
            end
            ans.empty = 1'b0;
            owed_answers.insert(owed_answers.size(), ans);
        endfunction

        function void flag(string msg);
            n_errors++;
            $error("%s", msg);
        endfunction

        function void check_answer(logic [PAL_AW-1:0] best, logic empty);
            nearest_t want;
            n_checked++;
            if (owed_answers.size() == 0)
            begin
                flag($sformatf("result word with none owed: best_entry %0d, palette_empty %0d",
                               best, empty));
                return;
            end
            want = owed_answers.pop_front();
            if (best !== want.best)
            begin
                flag($sformatf("best_entry: expected %0d, actual %0d", want.best, best));
            end
            if (empty !== want.empty)
            begin
                flag($sformatf("palette_empty: expected %0d, actual %0d", want.empty, empty));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    npcc_item_if   item_ch ();
    npcc_result_if result_ch ();
    npcc_cfg_if    cfg_ch ();

    nearest_palette_color_cached_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    nearest_color_board     matcher = new();
    int                     src_idle_pct = 36;
    int                     snk_idle_pct = 63;
    int                     stall_cycles = 0;
    logic signed [IN_W-1:0] recent_r [RECENT_DEPTH];
    logic signed [IN_W-1:0] recent_g [RECENT_DEPTH];
    logic signed [IN_W-1:0] recent_b [RECENT_DEPTH];
    int                     recent_n = 0;
    int                     recent_wr = 0;
    int                     phase_no = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // compare every result word taken from the block
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            matcher.check_answer(result_ch.best_entry, result_ch.palette_empty);
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic color_item_t make_item(logic c, int slot, int r, int g, int b);
        color_item_t w;
        w.cmd        = c;
        w.entry_slot = PAL_AW'(slot);
        w.red        = IN_W'(r);
        w.green      = IN_W'(g);
        w.blue       = IN_W'(b);
        return w;
    endfunction

    // load to any slot, mostly in-range colours, some needing saturation
    function automatic color_item_t random_load();
        if ($urandom_range(99) < 70)
        begin
            return make_item(CMD_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 255));
        end
        return make_item(CMD_LOAD, $urandom_range(0, 255), $urandom, $urandom, $urandom);
    endfunction

    // query colours: raw 10-bit, repeats or same-bucket neighbors, near an entry
    function automatic color_item_t random_query();
        color_item_t w;
        int          pick;
        int          k;
        int unsigned count;
        int          idx;
        w    = make_item(CMD_QUERY, $urandom, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255));
        pick = $urandom_range(99);
        count = (matcher.size_reg > PAL_DEPTH) ? PAL_DEPTH : matcher.size_reg;
        if (pick < 20)
        begin
            w.red   = IN_W'($urandom);
            w.green = IN_W'($urandom);
            w.blue  = IN_W'($urandom);
        end
        else if (pick < 55 && recent_n > 0)
        begin
            k       = $urandom_range(0, recent_n - 1);
            w.red   = recent_r[k];
            w.green = recent_g[k];
            w.blue  = recent_b[k];
            // keeping the upper bits keeps the bucket, even for clamped values
            if ($urandom_range(1) == 1)
            begin
                w.red   = {w.red[IN_W-1:3], 3'($urandom)};
                w.green = {w.green[IN_W-1:3], 3'($urandom)};
                w.blue  = {w.blue[IN_W-1:3], 3'($urandom)};
            end
        end
        else if (pick < 75 && count > 0)
        begin
            idx     = $urandom_range(0, count - 1);
            w.red   = IN_W'(int'(matcher.pal_r[idx]) + int'($urandom_range(0, 8)) - 4);
            w.green = IN_W'(int'(matcher.pal_g[idx]) + int'($urandom_range(0, 8)) - 4);
            w.blue  = IN_W'(int'(matcher.pal_b[idx]) + int'($urandom_range(0, 8)) - 4);
        end
        recent_r[recent_wr] = w.red;
        recent_g[recent_wr] = w.green;
        recent_b[recent_wr] = w.blue;
        recent_wr = (recent_wr + 1) % RECENT_DEPTH;
        if (recent_n < RECENT_DEPTH)
        begin
            recent_n++;
        end
        return w;
    endfunction

    // mostly small sizes; zero, full depth and beyond depth now and then
    function automatic int unsigned pick_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
        begin
            return 0;
        end
        if (pick < 50)
        begin
            return $urandom_range(1, 8);
        end
        if (pick < 75)
        begin
            return $urandom_range(9, 32);
        end
        if (pick < 87)
        begin
            return $urandom_range(33, 255);
        end
        if (pick < 94)
        begin
            return PAL_DEPTH;
        end
        return $urandom_range(257, 511);
    endfunction

    // offer one item word, with random gaps, and hold it until taken
    task automatic push_item(input color_item_t w);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.cmd        <= w.cmd;
        item_ch.entry_slot <= w.entry_slot;
        item_ch.red        <= w.red;
        item_ch.green      <= w.green;
        item_ch.blue       <= w.blue;
        do
        begin
            @(posedge clk);
        end
        while (item_ch.ready !== 1'b1);
        matcher.take_item(w);
    endtask

    // stop offering items and wait until every owed answer is back
    task automatic wait_drained(input int extra);
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (matcher.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    // palette_size write, only once every owed answer is back
    task automatic write_size(input int unsigned v);
        wait_drained(SETTLE_CYCLES);
        @(negedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.palette_size <= SIZE_W'(v);
        do
        begin
            @(posedge clk);
        end
        while (cfg_ch.ready !== 1'b1);
        matcher.set_size(v);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_directed();
        // empty palette right after reset
        push_item(make_item(CMD_QUERY, 255, -512, 511, 0));
        // small palette, colours that need saturation, a duplicate entry
        push_item(make_item(CMD_LOAD, 0, -512, 511, 0));
        push_item(make_item(CMD_LOAD, 1, 511, -1, 255));
        push_item(make_item(CMD_LOAD, 2, 300, 256, 255));
        push_item(make_item(CMD_LOAD, 3, 0, 0, 0));
        push_item(make_item(CMD_LOAD, 4, 255, -300, 255));
        push_item(make_item(CMD_LOAD, 5, 16, 16, 16));
        push_item(make_item(CMD_LOAD, 255, -1, 128, 511));
        push_item(make_item(CMD_QUERY, 0, 100, 100, 100));
        write_size(6);
        // tie between two equal entries, clamped extremes
        push_item(make_item(CMD_QUERY, 0, 255, 0, 255));
        push_item(make_item(CMD_QUERY, 128, -512, -512, -512));
        push_item(make_item(CMD_QUERY, 1, 511, 511, 511));
        // distance tie, then a bucket answered with the first colour's winner
        push_item(make_item(CMD_QUERY, 2, 8, 8, 8));
        push_item(make_item(CMD_QUERY, 3, 15, 15, 15));
        // rewriting the size drops the bucket
        write_size(6);
        push_item(make_item(CMD_QUERY, 4, 15, 15, 15));
        push_item(make_item(CMD_QUERY, 5, 0, 250, 3));
        // a load drops the cache too
        push_item(make_item(CMD_LOAD, 0, -2, -2, -2));
        push_item(make_item(CMD_QUERY, 6, 0, 250, 3));
        write_size(1);
        push_item(make_item(CMD_QUERY, 7, 200, 100, 50));
        write_size(0);
        push_item(make_item(CMD_QUERY, 8, 511, 511, 511));
    endtask

    // random phases: one size write, then a run of loads and queries
    task automatic run_mode(input int mode);
        int          done;
        int          n;
        int unsigned sz;
        done = 0;
        if (mode == 0)
        begin
            src_idle_pct = 36;
            snk_idle_pct = 63;
            // fill every slot not yet written so any size is safe
            for (int s = 6; s < PAL_DEPTH - 1; s++)
            begin
                push_item(make_item(CMD_LOAD, s, $urandom, $urandom, $urandom));
                done++;
            end
        end
        else if (mode == 1)
        begin
            src_idle_pct = 63;
            snk_idle_pct = 36;
        end
        else
        begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        while (done < ITEMS_PER_MODE)
        begin
            case (phase_no)
                0: sz = PAL_DEPTH;
                1: sz = 511;
                2: sz = 1;
                default: sz = pick_size();
            endcase
            phase_no++;
            write_size(sz);
            n = $urandom_range(20, 60);
            for (int j = 0; j < n; j++)
            begin
                if ($urandom_range(99) < 12)
                begin
                    push_item(random_load());
                end
                else
                begin
                    push_item(random_query());
                end
            end
            done += n;
        end
    endtask

    // main sequence
    initial
    begin
        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.cmd          <= CMD_LOAD;
        item_ch.entry_slot   <= '0;
        item_ch.red          <= '0;
        item_ch.green        <= '0;
        item_ch.blue         <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.palette_size  <= '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (int m = 0; m < 3; m++)
        begin
            run_mode(m);
        end
        wait_drained(DRAIN_CYCLES);

        $display("covered %0d palette loads and %0d queries over %0d size writes",
                 matcher.n_loads, matcher.n_queries, matcher.n_sizes);
        $display("%0d empty-palette answers, %0d cache answers, %0d words compared, %0d mismatches",
                 matcher.n_empty, matcher.n_cached, matcher.n_checked, matcher.n_errors);
        if (matcher.n_errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/npcc_pkg.sv
hdl/npcc_if.sv
hdl/npcc_datapath.sv
hdl/npcc_ctrl.sv
hdl/nearest_palette_color_cached_unit.sv
sim/tb_top.sv
